@@ src/battery_gauge_filter_top_macros.svh @@
// Assertion macros shared by the battery gauge filter RTL.
// Each macro names the clock and the asynchronous reset of the including module.
`ifndef BATTERY_GAUGE_FILTER_TOP_MACROS_SVH
`define BATTERY_GAUGE_FILTER_TOP_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define BGF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside of reset.
`define BGF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/bgf_pkg.sv @@
`default_nettype none

package bgf_pkg;

	// Field widths of the item channels.
	localparam int MV_W    = 12;
	localparam int RATIO_W = 16;
	localparam int BAT_W   = 20;
	localparam int PCT_W   = 8;
	localparam int FILT_W  = 28;

	// Default parameter values.
	localparam int BURST_DEF         = 16;
	localparam int PRESENT_THRESH_DEF = 150;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;
	localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EMPTY   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL    = 2'd2;

	localparam logic [RATIO_W-1:0]    RATIO_RESET = 16'd2816;
	localparam logic [CFG_DATA_W-1:0] EMPTY_RESET = 20'd10000;
	localparam logic [CFG_DATA_W-1:0] FULL_RESET  = 20'd12600;
	localparam logic [RATIO_W-1:0]    RATIO_MIN   = 16'd256;
	localparam logic [CFG_DATA_W:0]   FULL_PAD_MV = 21'd100;

	// raw * 3300 / 4095 equals floor(raw * 220 / 273); 220 * ceil(2^30 / 273) gives
	// an exact reciprocal product for every 12-bit code.
	localparam int CONV_PROD_W = 42;
	localparam int CONV_SHIFT  = 30;
	localparam logic [29:0] CONV_MULT = 30'd865286620;

	// One-pole filter, alpha = 13107 / 65536.
	localparam logic [13:0] ALPHA_Q16     = 14'd13107;
	localparam logic [15:0] ONE_MINUS_Q16 = 16'd52429;
	localparam logic [44:0] FILT_ROUND    = 45'd32768;

	// Shared iterative divider.
	localparam int DIV_N_W = 37;
	localparam int DIV_D_W = 30;
	localparam int DIV_Q_W = 12;

	localparam logic [6:0] PCT_FULL  = 7'd100;
	localparam logic [PCT_W-1:0] PCT_ABSENT = 8'hFF;

	typedef struct packed {
		logic capture;
		logic acc_add;
		logic burst_clear;
		logic div_start;
		logic div_sel_pct;
		logic pin_load;
		logic vmul;
		logic fmul_a;
		logic fmul_b;
		logic filt_upd;
		logic pct_cmp;
		logic pct_take;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic good_zero;
		logic div_done;
		logic pct_direct;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

@@ src/bgf_in_if.sv @@
`default_nettype none

interface bgf_in_if;
	logic                     valid;
	logic                     ready;
	logic                     read_ok;
	logic                     cal_ok;
	logic [bgf_pkg::MV_W-1:0] raw_code;
	logic [bgf_pkg::MV_W-1:0] cal_mv;

	modport source (output valid, read_ok, cal_ok, raw_code, cal_mv, input ready);
	modport sink   (input valid, read_ok, cal_ok, raw_code, cal_mv, output ready);
endinterface

`default_nettype wire

@@ src/bgf_out_if.sv @@
`default_nettype none

interface bgf_out_if;
	logic                             valid;
	logic                             ready;
	logic [bgf_pkg::MV_W-1:0]         pin_mv;
	logic                             present;
	logic [bgf_pkg::BAT_W-1:0]        battery_mv;
	logic signed [bgf_pkg::PCT_W-1:0] percent;

	modport source (output valid, pin_mv, present, battery_mv, percent, input ready);
	modport sink   (input valid, pin_mv, present, battery_mv, percent, output ready);
endinterface

`default_nettype wire

@@ src/bgf_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle. The quotient must fit DIV_Q_W bits.
module bgf_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [bgf_pkg::DIV_N_W-1:0] dividend,
	input  wire logic [bgf_pkg::DIV_D_W-1:0] divisor,
	output logic                             done,
	output logic [bgf_pkg::DIV_Q_W-1:0]      quotient
);
	localparam int DEN_W = bgf_pkg::DIV_D_W + bgf_pkg::DIV_Q_W - 1;
	localparam int CNT_W = $clog2(bgf_pkg::DIV_Q_W + 1);

	logic [bgf_pkg::DIV_N_W-1:0] rem_q;
	logic [DEN_W-1:0]            den_q;
	logic [bgf_pkg::DIV_Q_W-1:0] quo_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        done_q;
	logic                        fits;

	assign fits = DEN_W'(rem_q) >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(bgf_pkg::DIV_Q_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			den_q <= {divisor, {(bgf_pkg::DIV_Q_W-1){1'b0}}};
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q <= rem_q - den_q[bgf_pkg::DIV_N_W-1:0];
			end
			den_q <= den_q >> 1;
			quo_q <= {quo_q[bgf_pkg::DIV_Q_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

`default_nettype wire

@@ src/bgf_ctrl.sv @@
`default_nettype none

module bgf_ctrl #(
	parameter int BURST = bgf_pkg::BURST_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire bgf_pkg::sts_t sts,
	output bgf_pkg::cmd_t      cmd
);
	localparam int CNT_W = $clog2(BURST + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ACC  = 4'd1;
	localparam logic [3:0] S_CHK  = 4'd2;
	localparam logic [3:0] S_DIVP = 4'd3;
	localparam logic [3:0] S_VMUL = 4'd4;
	localparam logic [3:0] S_FMA  = 4'd5;
	localparam logic [3:0] S_FMB  = 4'd6;
	localparam logic [3:0] S_FUPD = 4'd7;
	localparam logic [3:0] S_PCMP = 4'd8;
	localparam logic [3:0] S_PDIV = 4'd9;
	localparam logic [3:0] S_DIVQ = 4'd10;
	localparam logic [3:0] S_OUT  = 4'd11;

	logic [3:0]       state_q, state_d;
	logic [CNT_W-1:0] attempt_q, attempt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			attempt_q <= '0;
		end else begin
			state_q   <= state_d;
			attempt_q <= attempt_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d   = state_q;
		attempt_d = attempt_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_ACC;
				end
			end
			S_ACC: begin
				cmd.acc_add = 1'b1;
				if (attempt_q == CNT_W'(BURST - 1)) begin
					attempt_d = '0;
					state_d   = S_CHK;
				end else begin
					attempt_d = attempt_q + 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_CHK: begin
				if (sts.good_zero) begin
					cmd.burst_clear = 1'b1;
					state_d         = S_IDLE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIVP;
				end
			end
			S_DIVP: begin
				if (sts.div_done) begin
					cmd.pin_load    = 1'b1;
					cmd.burst_clear = 1'b1;
					state_d         = S_VMUL;
				end
			end
			S_VMUL: begin
				cmd.vmul = 1'b1;
				state_d  = S_FMA;
			end
			S_FMA: begin
				cmd.fmul_a = 1'b1;
				state_d    = S_FMB;
			end
			S_FMB: begin
				cmd.fmul_b = 1'b1;
				state_d    = S_FUPD;
			end
			S_FUPD: begin
				cmd.filt_upd = 1'b1;
				state_d      = S_PCMP;
			end
			S_PCMP: begin
				cmd.pct_cmp = 1'b1;
				state_d     = sts.pct_direct ? S_OUT : S_PDIV;
			end
			S_PDIV: begin
				cmd.div_start   = 1'b1;
				cmd.div_sel_pct = 1'b1;
				state_d         = S_DIVQ;
			end
			S_DIVQ: begin
				if (sts.div_done) begin
					cmd.pct_take = 1'b1;
					state_d      = S_OUT;
				end
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

`default_nettype wire

@@ src/bgf_datapath.sv @@
`default_nettype none

module bgf_datapath #(
	parameter int BURST                = bgf_pkg::BURST_DEF,
	parameter int PRESENT_THRESHOLD_MV = bgf_pkg::PRESENT_THRESH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input item payload
	input  wire logic                           read_ok,
	input  wire logic                           cal_ok,
	input  wire logic [bgf_pkg::MV_W-1:0]       raw_code,
	input  wire logic [bgf_pkg::MV_W-1:0]       cal_mv,
	// configuration writes
	input  wire logic                           cfg_we,
	input  wire logic [bgf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bgf_pkg::CFG_DATA_W-1:0] cfg_data,
	// result item
	output logic                                res_valid,
	input  wire logic                           res_ready,
	output logic [bgf_pkg::MV_W-1:0]            res_pin_mv,
	output logic                                res_present,
	output logic [bgf_pkg::BAT_W-1:0]           res_battery_mv,
	output logic signed [bgf_pkg::PCT_W-1:0]    res_percent,
	// control
	input  wire bgf_pkg::cmd_t                  cmd,
	output bgf_pkg::sts_t                       sts
);
	localparam int CNT_W  = $clog2(BURST + 1);
	localparam int SUM_W  = $clog2(BURST * 4095 + 1);
	localparam int SPAN_W = bgf_pkg::FILT_W + 1;

	logic [bgf_pkg::RATIO_W-1:0]    ratio_q;
	logic [bgf_pkg::CFG_DATA_W-1:0] empty_q, full_q;

	logic [bgf_pkg::CONV_PROD_W-1:0] conv_prod;
	logic [bgf_pkg::MV_W-1:0]        conv_mv;
	logic [bgf_pkg::MV_W-1:0]        mv_s1;
	logic                            ok_s1;

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] good_q;

	logic [bgf_pkg::MV_W-1:0]    pin_q;
	logic                        present_q;
	logic [bgf_pkg::RATIO_W-1:0] ratio_eff;
	logic [bgf_pkg::FILT_W-1:0]  v_q, filt_q;
	logic                        first_q;
	logic [43:0]                 pa_q;
	logic [41:0]                 pb_q;
	logic [44:0]                 filt_sum;

	logic [bgf_pkg::FILT_W-1:0]  e_lvl;
	logic [bgf_pkg::CFG_DATA_W:0] hi_mv;
	logic [SPAN_W-1:0]           f_lvl;
	logic [SPAN_W-1:0]           span_q, diff_q;
	logic                        at_empty, at_full;
	logic [6:0]                  pct_q;
	logic [bgf_pkg::DIV_N_W-1:0] pct_dividend;

	logic [bgf_pkg::DIV_N_W-1:0] div_n;
	logic [bgf_pkg::DIV_D_W-1:0] div_d;
	logic                        div_done;
	logic [bgf_pkg::DIV_Q_W-1:0] div_quo;

	logic                        out_valid_q;
	logic [bgf_pkg::BAT_W-1:0]   bat_q;
	logic [bgf_pkg::MV_W-1:0]    out_pin_q;
	logic                        out_present_q;
	logic [bgf_pkg::PCT_W-1:0]   out_pct_q;
	logic [bgf_pkg::FILT_W:0]    bat_round;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= bgf_pkg::RATIO_RESET;
			empty_q <= bgf_pkg::EMPTY_RESET;
			full_q  <= bgf_pkg::FULL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bgf_pkg::CFG_DIVIDER: ratio_q <= cfg_data[bgf_pkg::RATIO_W-1:0];
				bgf_pkg::CFG_EMPTY:   empty_q <= cfg_data;
				bgf_pkg::CFG_FULL:    full_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Raw code to pin millivolts by reciprocal multiplication.
	assign conv_prod = bgf_pkg::CONV_PROD_W'(raw_code)
		* bgf_pkg::CONV_PROD_W'(bgf_pkg::CONV_MULT);
	assign conv_mv   = conv_prod[bgf_pkg::CONV_SHIFT +: bgf_pkg::MV_W];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ok_s1 <= read_ok;
			mv_s1 <= cal_ok ? cal_mv : conv_mv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			good_q <= '0;
		end else if (cmd.burst_clear) begin
			sum_q  <= '0;
			good_q <= '0;
		end else if (cmd.acc_add && ok_s1) begin
			sum_q  <= sum_q + SUM_W'(mv_s1);
			good_q <= good_q + 1'b1;
		end
	end

	// Shared divider: burst average, then charge percent.
	assign pct_dividend = bgf_pkg::DIV_N_W'(diff_q) * bgf_pkg::DIV_N_W'(200)
		+ bgf_pkg::DIV_N_W'(span_q);
	assign div_n = cmd.div_sel_pct ? pct_dividend : bgf_pkg::DIV_N_W'(sum_q);
	assign div_d = cmd.div_sel_pct ? bgf_pkg::DIV_D_W'({span_q, 1'b0})
		: bgf_pkg::DIV_D_W'(good_q);

	bgf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign ratio_eff = (ratio_q < bgf_pkg::RATIO_MIN) ? bgf_pkg::RATIO_MIN : ratio_q;
	assign filt_sum  = 45'(pa_q) + 45'(pb_q) + bgf_pkg::FILT_ROUND;

	always_ff @(posedge clk) begin
		if (cmd.pin_load) begin
			pin_q     <= div_quo;
			present_q <= div_quo > bgf_pkg::MV_W'(PRESENT_THRESHOLD_MV);
		end
		if (cmd.vmul) begin
			v_q <= bgf_pkg::FILT_W'(pin_q) * bgf_pkg::FILT_W'(ratio_eff);
		end
		if (cmd.fmul_a) begin
			pa_q <= 44'(filt_q) * 44'(bgf_pkg::ONE_MINUS_Q16);
		end
		if (cmd.fmul_b) begin
			pb_q <= 42'(v_q) * 42'(bgf_pkg::ALPHA_Q16);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q  <= '0;
			first_q <= 1'b1;
		end else if (cmd.filt_upd) begin
			filt_q  <= first_q ? v_q : filt_sum[16 +: bgf_pkg::FILT_W];
			first_q <= 1'b0;
		end
	end

	// Percent window in Q8 millivolts.
	assign e_lvl    = {empty_q, 8'b0};
	assign hi_mv    = (full_q <= empty_q) ? ({1'b0, empty_q} + bgf_pkg::FULL_PAD_MV)
		: {1'b0, full_q};
	assign f_lvl    = {hi_mv, 8'b0};
	assign at_empty = filt_q <= e_lvl;
	assign at_full  = SPAN_W'(filt_q) >= f_lvl;

	always_ff @(posedge clk) begin
		if (cmd.pct_cmp) begin
			span_q <= f_lvl - SPAN_W'(e_lvl);
			diff_q <= SPAN_W'(filt_q) - SPAN_W'(e_lvl);
			pct_q  <= at_empty ? 7'd0 : bgf_pkg::PCT_FULL;
		end else if (cmd.pct_take) begin
			pct_q <= div_quo[6:0];
		end
	end

	assign bat_round = {1'b0, filt_q} + (bgf_pkg::FILT_W+1)'(128);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_pin_q     <= pin_q;
			out_present_q <= present_q;
			bat_q         <= present_q ? bat_round[8 +: bgf_pkg::BAT_W] : '0;
			out_pct_q     <= present_q ? {1'b0, pct_q} : bgf_pkg::PCT_ABSENT;
		end
	end

	assign sts.good_zero  = (good_q == '0);
	assign sts.div_done   = div_done;
	assign sts.pct_direct = at_empty || at_full;
	assign sts.out_free   = !out_valid_q || res_ready;

	assign res_valid      = out_valid_q;
	assign res_pin_mv     = out_pin_q;
	assign res_present    = out_present_q;
	assign res_battery_mv = bat_q;
	assign res_percent    = out_pct_q;
endmodule

`default_nettype wire

@@ src/battery_gauge_filter_top.sv @@
`default_nettype none

// Battery gauge built from bursts of ADC reads. Each input item is one read
// attempt; failed reads are skipped and good reads add either the calibrated
// millivolts or the raw code scaled by 3300/4095. Every BURST attempts, a burst
// with at least one good read yields one result item: the averaged pin voltage,
// a presence flag (pin above PRESENT_THRESHOLD_MV), the battery voltage after
// the divider ratio and a one-pole low-pass filter (alpha 0.2, the first burst
// loads the filter directly), and the charge percent between the empty and full
// levels, rounded half up. When the battery is absent the voltage reads 0 and
// the percent reads -1. A burst without a good read yields nothing. Configuration
// is written through cfg_we, cfg_index and cfg_data, by the user only while the
// block is idle (not enforced by the block); index 0 is the Q8.8 divider ratio
// (below 1.0 is treated as 1.0), 1 the empty level and 2 the full level in
// millivolts. An ordinary item is captured and converted, then accumulated. The
// last item of a burst is followed by the burst work, of which the passes
// through the shared restoring divider (the average, then the percent if not at
// empty or full) take the most; no item is accepted meanwhile. A finished result
// sits in an output register, so the block moves on as soon as it is loaded.
module battery_gauge_filter_top #(
	parameter int BURST                = bgf_pkg::BURST_DEF,
	parameter int PRESENT_THRESHOLD_MV = bgf_pkg::PRESENT_THRESH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	bgf_in_if.sink                              sample,
	bgf_out_if.source                           result,
	input  wire logic                           cfg_we,
	input  wire logic [bgf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bgf_pkg::CFG_DATA_W-1:0] cfg_data
);
	`include "battery_gauge_filter_top_macros.svh"

	bgf_pkg::cmd_t cmd;
	bgf_pkg::sts_t sts;
	logic          in_ready;

	// The controller sequences capture, accumulation and the per-burst work.
	bgf_ctrl #(
		.BURST (BURST)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the configuration, the burst sums, the filter and the
	// output register.
	bgf_datapath #(
		.BURST                (BURST),
		.PRESENT_THRESHOLD_MV (PRESENT_THRESHOLD_MV)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.read_ok        (sample.read_ok),
		.cal_ok         (sample.cal_ok),
		.raw_code       (sample.raw_code),
		.cal_mv         (sample.cal_mv),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.res_valid      (result.valid),
		.res_ready      (result.ready),
		.res_pin_mv     (result.pin_mv),
		.res_present    (result.present),
		.res_battery_mv (result.battery_mv),
		.res_percent    (result.percent),
		.cmd            (cmd),
		.sts            (sts)
	);

	assign sample.ready = in_ready;

	// An accepted item is always accumulated in the following cycle.
	`BGF_ASSERT_NEXT(a_accept_then_add, sample.valid && sample.ready, cmd.acc_add,
		"accepted item was not accumulated")
	// No new item is taken while a division is running.
	`BGF_ASSERT_NEXT(a_busy_in_div, cmd.div_start, !sample.ready,
		"input ready while divider was started")
	// A result is only loaded when the output register is free or draining.
	`BGF_ASSERT_NOW(a_out_free, cmd.out_load, sts.out_free,
		"result loaded over an untaken result")
	// An absent battery reports zero volts and percent of -1.
	`BGF_ASSERT_NOW(a_absent_fields, result.valid && !result.present,
		(result.battery_mv == '0) && (result.percent == -8'sd1),
		"absent battery with nonzero voltage or percent")
endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
module tb_top;
	import bgf_pkg::*;

	// The block is built with its default burst length and presence threshold.
	localparam int GROUP  = BURST_DEF;
	localparam int THRESH = PRESENT_THRESH_DEF;

	// Register index 3 is not decoded by the block; writes to it must be dropped.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	// Filter weights in Q16: the old value keeps 52429/65536, the new one adds 13107/65536.
	localparam logic [63:0] KEEP_Q16   = 64'd52429;
	localparam logic [63:0] TAKE_Q16   = 64'd13107;
	localparam logic [63:0] ROUND_Q16  = 64'd32768;
	localparam logic [63:0] ROUND_Q8   = 64'd128;
	localparam logic [15:0] RATIO_FLOOR = 16'd256;

	// Cycles to wait once nothing is expected, so that the burst work after the last item of
	// a burst can finish; a burst with no good read gives no result to wait on.
	localparam int SETTLE_CYCLES = 60;
	// Length of the deliberate hold-off on the result side.
	localparam int HOLD_CYCLES   = 400;
	// Cycles without any accepted item before the run is declared hung. The longest quiet
	// stretch in a correct run is the hold-off plus burst work, well below this.
	localparam int QUIET_LIMIT   = 3000;

	typedef struct packed {
		logic             read_ok;
		logic             cal_ok;
		logic [MV_W-1:0]  raw_code;
		logic [MV_W-1:0]  cal_mv;
	} read_t;

	typedef struct packed {
		logic [MV_W-1:0]         pin_mv;
		logic                    present;
		logic [BAT_W-1:0]        battery_mv;
		logic signed [PCT_W-1:0] percent;
	} gauge_t;

	// Kinds of burst the random part is built from.
	typedef enum {
		SHAPE_MIXED,     // mostly good reads over the whole voltage range
		SHAPE_EMPTY,     // every read fails, so the burst yields nothing
		SHAPE_ABSENT,    // low pin voltages, battery reads as absent
		SHAPE_THRESHOLD, // averages right around the presence threshold
		SHAPE_WINDOW,    // battery voltage between the empty and full levels
		SHAPE_NOISE      // half the reads fail, fields fully random
	} burst_shape_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bgf_in_if  sample_if();
	bgf_out_if result_if();

	battery_gauge_filter_top #(
		.BURST                (GROUP),
		.PRESENT_THRESHOLD_MV (THRESH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_if),
		.result    (result_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Register copies as the gauge sees them.
	logic [RATIO_W-1:0]    set_ratio = RATIO_RESET;
	logic [CFG_DATA_W-1:0] set_empty = EMPTY_RESET;
	logic [CFG_DATA_W-1:0] set_full  = FULL_RESET;

	// Gauge state: burst accumulator, counters and the filtered battery voltage in Q8.
	logic [17:0]       mv_total    = '0;
	logic [6:0]        good_reads  = '0;
	logic [6:0]        attempts    = '0;
	logic [FILT_W-1:0] filt_q8     = '0;
	logic              first_burst = 1'b1;

	read_t  reads_to_send[$];  // read attempts waiting to be offered
	gauge_t gauge_due[$];      // gauge readings the block still owes us

	int reads_queued = 0;
	int reads_taken  = 0;
	int errors       = 0;
	int quiet        = 0;
	int send_gap     = 0;
	int drain_wait   = 0;
	int hold_asked   = 0;
	int hold_served  = 0;
	bit calm         = 1'b0;  // when set, neither side inserts idle cycles
	bit in_fire      = 1'b0;  // a read attempt was accepted at the last rising edge

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Charge percent of a filtered level against the current empty and full settings,
	// rounded half up. A full level not above empty is taken as empty plus 100 mV.
	function automatic logic [PCT_W-1:0] charge_level(input logic [FILT_W-1:0] level_q8);
		logic [63:0] lo_q8;
		logic [63:0] hi_q8;
		logic [63:0] span;
		lo_q8 = 64'(set_empty) << 8;
		if (set_full > set_empty)
			hi_q8 = 64'(set_full) << 8;
		else
			hi_q8 = (64'(set_empty) + 64'd100) << 8;
		if (64'(level_q8) <= lo_q8)
			return '0;
		if (64'(level_q8) >= hi_q8)
			return PCT_W'(PCT_FULL);
		span = hi_q8 - lo_q8;
		return PCT_W'((64'd200 * (64'(level_q8) - lo_q8) + span) / (64'd2 * span));
	endfunction

	// Takes one read attempt into the gauge. Returns 1 with the reading when the attempt
	// closes a burst that had at least one good read.
	function automatic bit advance_gauge(input read_t rd, output gauge_t res);
		logic [MV_W-1:0]    mv;
		logic [MV_W-1:0]    pin;
		logic [RATIO_W-1:0] ratio;
		logic [63:0]        scaled;
		logic [63:0]        blend;
		res = '0;
		if (rd.read_ok) begin
			// Without calibration the raw code is scaled by 3300/4095, truncated.
			mv = rd.cal_ok ? rd.cal_mv : MV_W'((32'(rd.raw_code) * 32'd3300) / 32'd4095);
			mv_total = mv_total + 18'(mv);
			good_reads = good_reads + 7'd1;
		end
		attempts = attempts + 7'd1;
		if (attempts < GROUP)
			return 1'b0;
		attempts = '0;
		if (good_reads == '0) begin
			// A burst without a good read leaves filter and presence untouched.
			mv_total = '0;
			return 1'b0;
		end
		pin = MV_W'(mv_total / good_reads);
		mv_total = '0;
		good_reads = '0;
		ratio = (set_ratio < RATIO_FLOOR) ? RATIO_FLOOR : set_ratio;
		scaled = 64'(pin) * 64'(ratio);
		if (first_burst)
			blend = scaled;
		else
			blend = (64'(filt_q8) * KEEP_Q16 + scaled * TAKE_Q16 + ROUND_Q16) >> 16;
		filt_q8 = FILT_W'(blend);
		first_burst = 1'b0;
		res.pin_mv = pin;
		res.present = pin > THRESH;
		if (res.present) begin
			res.battery_mv = BAT_W'((64'(filt_q8) + ROUND_Q8) >> 8);
			res.percent = charge_level(filt_q8);
		end else begin
			// The filter keeps running while the battery is absent; only the outputs change.
			res.battery_mv = '0;
			res.percent = PCT_ABSENT;
		end
		return 1'b1;
	endfunction

	function automatic void push_read(input bit ok, input bit cal, input int raw, input int cal_val);
		read_t rd;
		rd.read_ok = ok;
		rd.cal_ok = cal;
		rd.raw_code = MV_W'(raw);
		rd.cal_mv = MV_W'(cal_val);
		reads_to_send.push_back(rd);
		reads_queued++;
	endfunction

	function automatic burst_shape_t pick_shape();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 35)
			return SHAPE_WINDOW;
		if (roll < 55)
			return SHAPE_MIXED;
		if (roll < 65)
			return SHAPE_THRESHOLD;
		if (roll < 75)
			return SHAPE_ABSENT;
		if (roll < 85)
			return SHAPE_EMPTY;
		return SHAPE_NOISE;
	endfunction

	// Queues one burst of read attempts. Each good read targets a pin voltage in a range
	// chosen by the shape; it arrives either calibrated or as a raw code that converts back
	// to roughly that voltage, and the unused field carries random bits.
	task automatic queue_burst(input burst_shape_t shape);
		int ok_pct;
		int mv_lo;
		int mv_hi;
		int mv;
		int raw;
		longint unsigned ratio_eff;
		longint unsigned top_mv;
		longint unsigned lo_pin;
		longint unsigned hi_pin;
		longint unsigned margin;
		ok_pct = 85;
		mv_lo = 0;
		mv_hi = 4095;
		case (shape)
			SHAPE_EMPTY: begin
				ok_pct = 0;
			end
			SHAPE_ABSENT: begin
				ok_pct = 90;
				mv_hi = THRESH;
			end
			SHAPE_THRESHOLD: begin
				ok_pct = 100;
				mv_lo = THRESH - 5;
				mv_hi = THRESH + 5;
			end
			SHAPE_NOISE: begin
				ok_pct = 50;
			end
			SHAPE_WINDOW: begin
				// Map the empty and full levels back to pin millivolts and aim a bit beyond.
				ok_pct = 90;
				ratio_eff = (set_ratio < RATIO_FLOOR) ? RATIO_FLOOR : set_ratio;
				top_mv = (set_full > set_empty) ? set_full : longint'(set_empty) + 100;
				lo_pin = (longint'(set_empty) * 256) / ratio_eff;
				hi_pin = (top_mv * 256) / ratio_eff;
				margin = (hi_pin - lo_pin) / 8 + 2;
				mv_lo = int'((lo_pin > margin) ? lo_pin - margin : 0);
				mv_hi = int'((hi_pin + margin > 4095) ? 4095 : hi_pin + margin);
				if (mv_lo > 4000)
					mv_lo = 4000;
			end
			default: begin
			end
		endcase
		repeat (GROUP) begin
			mv = $urandom_range(mv_lo, mv_hi);
			raw = (mv * 4095 + 3299) / 3300;
			if (raw > 4095)
				raw = 4095;
			if ($urandom_range(0, 1))
				push_read($urandom_range(0, 99) < ok_pct, 1'b1, $urandom_range(0, 4095), mv);
			else
				push_read($urandom_range(0, 99) < ok_pct, 1'b0, raw, $urandom_range(0, 4095));
		end
	endtask

	// Writes one register at a falling edge and mirrors it in the gauge copy. Index 3 is
	// not a register and changes nothing.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_DIVIDER: set_ratio = data[RATIO_W-1:0];
			CFG_EMPTY:   set_empty = data;
			CFG_FULL:    set_full = data;
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until every queued attempt is taken and every reading has come back, then
	// lets the block finish any burst that produced no reading.
	task automatic settle_block();
		while (reads_taken != reads_queued || gauge_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One phase of random bursts under the current settings. A squeezed phase asks the
	// result side for a long hold-off while the attempts of the phase are still on offer.
	task automatic run_phase(input int bursts, input bit no_idle, input bit squeeze);
		calm = no_idle;
		repeat (bursts) queue_burst(pick_shape());
		if (squeeze)
			hold_asked++;
		settle_block();
	endtask

	// Sender: offers queued read attempts, holding each until it is taken, with random
	// gaps between them.
	always @(negedge clk) begin : feed
		read_t nxt;
		if (!arst_n) begin
			sample_if.valid <= 1'b0;
		end else if (sample_if.valid && !in_fire) begin
			// The attempt on offer was not taken yet, so it stays.
		end else if (send_gap > 0) begin
			sample_if.valid <= 1'b0;
			send_gap--;
		end else if (reads_to_send.size() > 0) begin
			nxt = reads_to_send.pop_front();
			sample_if.valid <= 1'b1;
			sample_if.read_ok <= nxt.read_ok;
			sample_if.cal_ok <= nxt.cal_ok;
			sample_if.raw_code <= nxt.raw_code;
			sample_if.cal_mv <= nxt.cal_mv;
			send_gap = calm ? 0 : pick_gap();
		end else begin
			sample_if.valid <= 1'b0;
		end
	end

	// Receiver: mostly ready, with random stalls, plus the long hold-off when asked.
	always @(negedge clk) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
		end else if (hold_asked != hold_served) begin
			hold_served = hold_asked;
			drain_wait = HOLD_CYCLES;
			result_if.ready <= 1'b0;
		end else if (drain_wait > 0) begin
			drain_wait--;
			result_if.ready <= 1'b0;
		end else begin
			result_if.ready <= 1'b1;
			if (!calm && $urandom_range(0, 3) == 0)
				drain_wait = pick_gap();
		end
	end

	// Monitor: checks every result item against the oldest expected reading, feeds every
	// accepted read attempt to the gauge copy, and watches for a hung block.
	always @(posedge clk) begin : watch
		gauge_t got;
		gauge_t want;
		gauge_t fresh;
		read_t  rd;
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= sample_if.valid && sample_if.ready;
			if (result_if.valid && result_if.ready) begin
				got.pin_mv = result_if.pin_mv;
				got.present = result_if.present;
				got.battery_mv = result_if.battery_mv;
				got.percent = result_if.percent;
				if (gauge_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected reading pin %0d present %0b battery %0d pct %0d",
							$realtime, got.pin_mv, got.present, got.battery_mv, got.percent);
				end else begin
					want = gauge_due.pop_front();
					if (got.pin_mv !== want.pin_mv || got.present !== want.present ||
							got.battery_mv !== want.battery_mv || got.percent !== want.percent) begin
						errors++;
						if (errors <= 10) begin
							$write("%0t: reading mismatch, expected pin %0d present %0b ",
								$realtime, want.pin_mv, want.present);
							$write("battery %0d pct %0d, ", want.battery_mv, want.percent);
							$display("got pin %0d present %0b battery %0d pct %0d",
								got.pin_mv, got.present, got.battery_mv, got.percent);
						end
					end
				end
			end
			if (sample_if.valid && sample_if.ready) begin
				rd.read_ok = sample_if.read_ok;
				rd.cal_ok = sample_if.cal_ok;
				rd.raw_code = sample_if.raw_code;
				rd.cal_mv = sample_if.cal_mv;
				reads_taken++;
				if (advance_gauge(rd, fresh))
					gauge_due.push_back(fresh);
			end
			if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= QUIET_LIMIT) begin
					$display("== FAIL ==");
					$finish;
				end
			end
		end
	end

	initial begin
		int lo_mv;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_if.valid = 1'b0;
		sample_if.read_ok = 1'b0;
		sample_if.cal_ok = 1'b0;
		sample_if.raw_code = '0;
		sample_if.cal_mv = '0;
		result_if.ready = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Directed burst under the reset settings: field extremes on both the calibrated
		// and the raw path, failed reads whose fields must be ignored, the smallest raw
		// codes that truncate, and calibrated values on both sides of the threshold.
		push_read(1'b1, 1'b1, 0, 4095);
		push_read(1'b1, 1'b0, 4095, 0);
		push_read(1'b1, 1'b0, 0, 4095);
		push_read(1'b1, 1'b1, 4095, 0);
		push_read(1'b0, 1'b1, 4095, 4095);
		push_read(1'b0, 1'b0, 0, 0);
		push_read(1'b1, 1'b0, 1, 2730);
		push_read(1'b1, 1'b0, 4094, 1365);
		push_read(1'b1, 1'b0, 2048, 4095);
		push_read(1'b1, 1'b1, 2730, THRESH);
		push_read(1'b1, 1'b1, 1365, THRESH + 1);
		push_read(1'b0, 1'b0, 4095, 4095);
		push_read(1'b1, 1'b1, 0, 1000);
		push_read(1'b1, 1'b1, 4095, 1100);
		push_read(1'b1, 1'b0, 1241, 0);
		push_read(1'b1, 1'b0, 1365, 2048);
		// A burst of failed reads right after: nothing comes out and the filter holds.
		queue_burst(SHAPE_EMPTY);
		run_phase(14, 1'b0, 1'b0);

		// A ratio of zero is treated as 1.0; full equal to empty uses empty plus 100 mV.
		write_reg(CFG_DIVIDER, '0);
		write_reg(CFG_EMPTY, '0);
		write_reg(CFG_FULL, '0);
		write_reg(CFG_SPARE, '1);
		run_phase(15, 1'b0, 1'b0);

		// Largest ratio with spare upper data bits set; full below the largest empty level.
		// This phase runs without idle cycles on either side.
		write_reg(CFG_DIVIDER, '1);
		write_reg(CFG_EMPTY, '1);
		write_reg(CFG_FULL, 20'd1000000);
		run_phase(15, 1'b1, 1'b0);

		// Ratio just below 1.0, a window the pin range reaches, and a long result stall.
		write_reg(CFG_DIVIDER, {4'ha, 16'd255});
		write_reg(CFG_EMPTY, 20'd500);
		write_reg(CFG_FULL, 20'd3000);
		run_phase(15, 1'b0, 1'b1);

		// Exactly 1.0 and the widest possible window.
		write_reg(CFG_DIVIDER, 20'(RATIO_FLOOR));
		write_reg(CFG_EMPTY, '0);
		write_reg(CFG_FULL, '1);
		run_phase(15, 1'b0, 1'b0);

		// Random settings: now and then a ratio below 1.0 or a full level not above empty.
		for (int p = 0; p < 3; p++) begin
			lo_mv = $urandom_range(0, 60000);
			write_reg(CFG_DIVIDER, {4'($urandom), ($urandom_range(0, 3) == 0) ?
				16'($urandom_range(0, 255)) : 16'($urandom_range(256, 65535))});
			write_reg(CFG_EMPTY, 20'(lo_mv));
			write_reg(CFG_FULL, ($urandom_range(0, 4) == 0) ?
				20'($urandom_range(0, lo_mv)) : 20'(lo_mv + $urandom_range(1, 20000)));
			write_reg(CFG_SPARE, 20'($urandom));
			run_phase(15, p == 0, p == 1);
		end

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
